FILE: sv/bpp_pkg.sv
// Package with the shared widths, result types and output rounding of the pillar pooling block.
package bpp_pkg;

	// Channel store size and field widths.
	localparam int MAX_CHANNELS = 64;
	localparam int CH_W         = 6;
	localparam int ADDR_W       = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = 7;
	localparam int W_W          = 16;
	localparam int F_W          = 16;
	localparam int CELL_W       = 20;
	localparam int ACC_W        = 48;
	localparam int PROD_W       = W_W + F_W + 1;
	localparam int SUM_W        = 32;

	// Rounding from Q.23 accumulator to Q.8 output.
	localparam int ROUND_SHIFT  = 15;
	localparam int ROUND_BIAS   = 1 << (ROUND_SHIFT - 1);
	localparam int Q_W          = ACC_W + 1 - ROUND_SHIFT;

	// Result queue.
	localparam int OUTQ_DEPTH   = 8;
	localparam int OUTQ_AW      = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW      = $clog2(OUTQ_DEPTH) + 1;

	// Finished interval as it leaves the accumulator pipeline.
	typedef struct packed {
		logic [CELL_W-1:0]       cell_idx;
		logic [CH_W-1:0]         channel;
		logic signed [ACC_W-1:0] acc;
	} acc_res_t;

	// Rounded result as it is held in the output queue.
	typedef struct packed {
		logic [CELL_W-1:0]       cell_idx;
		logic [CH_W-1:0]         channel;
		logic signed [SUM_W-1:0] sum;
	} out_res_t;

	// Pipeline stages that hold an item which will produce a result.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pend_t;

	// Round to nearest (ties up) from Q.23 to Q.8 and saturate to 32 bits.
	function automatic logic signed [SUM_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0] t;
		logic [Q_W-1:0]        q;
		logic [SUM_W-1:0]      r;
		t = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(ROUND_BIAS));
		q = t[ACC_W:ROUND_SHIFT];
		if ((&q[Q_W-1:SUM_W-1]) || !(|q[Q_W-1:SUM_W-1])) begin
			r = q[SUM_W-1:0];
		end else if (q[Q_W-1]) begin
			r = {1'b1, {(SUM_W - 1){1'b0}}};
		end else begin
			r = {1'b0, {(SUM_W - 1){1'b1}}};
		end
		return $signed(r);
	endfunction

endpackage

FILE: sv/bev_pillar_pool_forward.sv
// Forward BEV pillar pooling: depth-weighted segmented sum per channel with queued results.
// One request is taken per cycle while in_stall is low. A request that closes an interval
// passes through stage 1, stage 2 and stage 3 before its rounded result enters the result
// queue, from where it is offered on out_valid. The rate is set by the read-modify-write
// loop on the 64-entry channel accumulator memory: a registered read, a multiply stage, then
// an add with forwarding from the write in flight and the most recent write, so elements of
// the same channel may follow each other in consecutive cycles. Finished sums are rounded
// into an eight-entry result queue; in_stall rises only when queued and in-flight results
// could fill it. The accumulators read as zero after reset with no clearing pass.
module bev_pillar_pool_forward
	import bpp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CNT_W-1:0]        cfg_write_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [W_W-1:0]          depth_weight,
	input  logic signed [F_W-1:0]   feature_value,
	input  logic [CH_W-1:0]         channel,
	input  logic [CELL_W-1:0]       cell_index,
	input  logic                    interval_last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CELL_W-1:0]       out_cell,
	output logic [CH_W-1:0]         out_channel,
	output logic signed [SUM_W-1:0] pooled_sum
);

	logic [CNT_W-1:0] channel_count_q;
	logic             in_accept;
	logic             res_valid;
	acc_res_t         res;
	pend_t            pend;

	// Channel count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CNT_W'(MAX_CHANNELS);
		end else if (cfg_write_en) begin
			channel_count_q <= cfg_write_data;
		end
	end

	assign in_accept = in_valid && !in_stall;

	bpp_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.depth_weight (depth_weight),
		.feature_value(feature_value),
		.channel      (channel),
		.cell_index   (cell_index),
		.interval_last(interval_last),
		.channel_count(channel_count_q),
		.res_valid    (res_valid),
		.res          (res),
		.pend         (pend)
	);

	bpp_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.pend       (pend),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_cell   (out_cell),
		.out_channel(out_channel),
		.pooled_sum (pooled_sum)
	);

endmodule

FILE: sv/bpp_ram.sv
// Generic single-write, single-read memory with a registered read port.
module bpp_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port returns the old contents on a same-address write.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/bpp_accum.sv
// Accumulator pipeline: channel memory read, multiply, forwarded add and write-back.
module bpp_accum
	import bpp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_accept,
	input  logic [W_W-1:0]          depth_weight,
	input  logic signed [F_W-1:0]   feature_value,
	input  logic [CH_W-1:0]         channel,
	input  logic [CELL_W-1:0]       cell_index,
	input  logic                    interval_last,
	input  logic [CNT_W-1:0]        channel_count,
	output logic                    res_valid,
	output acc_res_t                res,
	output pend_t                   pend
);

	// Stage 1: memory data arrives, product is formed.
	logic                    valid_s1;
	logic                    rd_ok_s1;
	logic [W_W-1:0]          weight_s1;
	logic signed [F_W-1:0]   feature_s1;
	logic [CH_W-1:0]         ch_s1;
	logic [CELL_W-1:0]       cell_s1;
	logic                    last_s1;

	// Stage 2: add, saturate, write back.
	logic                    valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_s2;
	logic [CH_W-1:0]         ch_s2;
	logic [CELL_W-1:0]       cell_s2;
	logic                    last_s2;

	// Stage 3: finished interval.
	logic                    valid_s3;
	acc_res_t                res_s3;

	// Most recent write to the memory, for forwarding.
	logic                    wb_valid_q;
	logic [CH_W-1:0]         wb_ch_q;
	logic signed [ACC_W-1:0] wb_data_q;

	// Entries written since reset; others read as zero.
	logic                    written_q [MAX_CHANNELS];

	logic                    ch_ok;
	logic                    take;
	logic [ACC_W-1:0]        rd_data;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] operand;
	logic signed [ACC_W:0]   sum;
	logic signed [ACC_W-1:0] new_acc;
	logic signed [ACC_W-1:0] wr_data;

	// Channels at or above the count in use are dropped at the door.
	assign ch_ok = (CNT_W'(channel) < channel_count) &&
		(CNT_W'(channel) < CNT_W'(MAX_CHANNELS));
	assign take  = in_accept && ch_ok;

	bpp_ram #(
		.WIDTH(ACC_W),
		.DEPTH(MAX_CHANNELS)
	) u_acc_ram (
		.clk  (clk),
		.we   (valid_s2),
		.waddr(ch_s2[ADDR_W-1:0]),
		.wdata(wr_data),
		.re   (in_accept),
		.raddr(channel[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_ok_s1   <= written_q[channel[ADDR_W-1:0]];
			weight_s1  <= depth_weight;
			feature_s1 <= feature_value;
			ch_s1      <= channel;
			cell_s1    <= cell_index;
			last_s1    <= interval_last;
		end
	end

	// Unsigned Q1.15 weight times signed Q8.8 feature, exact.
	assign prod = $signed({1'b0, weight_s1}) * feature_s1;

	// Pick the freshest value of the channel: the write in flight, the last write, or memory.
	always_comb begin
		if (valid_s2 && (ch_s2 == ch_s1)) begin
			operand = wr_data;
		end else if (wb_valid_q && (wb_ch_q == ch_s1)) begin
			operand = wb_data_q;
		end else if (rd_ok_s1) begin
			operand = $signed(rd_data);
		end else begin
			operand = '0;
		end
	end

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		acc_s2  <= operand;
		ch_s2   <= ch_s1;
		cell_s2 <= cell_s1;
		last_s2 <= last_s1;
	end

	// Add the product and saturate to the 48-bit range.
	always_comb begin
		sum = $signed({acc_s2[ACC_W-1], acc_s2}) +
			$signed({{(ACC_W + 1 - PROD_W){prod_s2[PROD_W-1]}}, prod_s2});
		if (sum[ACC_W] != sum[ACC_W-1]) begin
			new_acc = sum[ACC_W] ? $signed({1'b1, {(ACC_W - 1){1'b0}}})
				: $signed({1'b0, {(ACC_W - 1){1'b1}}});
		end else begin
			new_acc = sum[ACC_W-1:0];
		end
		wr_data = last_s2 ? '0 : new_acc;
	end

	// Track the last write and which entries hold data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				written_q[i] <= 1'b0;
			end
		end else if (valid_s2) begin
			wb_valid_q <= 1'b1;
			written_q[ch_s2[ADDR_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			wb_ch_q   <= ch_s2;
			wb_data_q <= wr_data;
		end
	end

	// Stage 3 holds the full sum of a finished interval.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		res_s3.cell_idx <= cell_s2;
		res_s3.channel  <= ch_s2;
		res_s3.acc      <= new_acc;
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;
	assign pend.s1   = valid_s1 && last_s1;
	assign pend.s2   = valid_s2 && last_s2;
	assign pend.s3   = valid_s3;

`ifndef NO_ASSERTIONS
	// A closing element in stage 2 yields a result for its own channel in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |=> (valid_s3 && (res_s3.channel == $past(ch_s2))))
		else $error("closing element did not produce its result");

	// A closing element leaves its channel cleared for the next element.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |=> (wb_valid_q && (wb_data_q == '0)))
		else $error("accumulator not cleared after interval end");

	// A dropped channel never enters the pipeline.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !ch_ok) |=> !valid_s1)
		else $error("out-of-range channel entered the pipeline");
`endif

endmodule

FILE: sv/bpp_outq.sv
// Output stage: rounds finished sums and queues them for the result channel.
module bpp_outq
	import bpp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    res_valid,
	input  acc_res_t                res,
	input  pend_t                   pend,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CELL_W-1:0]       out_cell,
	output logic [CH_W-1:0]         out_channel,
	output logic signed [SUM_W-1:0] pooled_sum
);

	out_res_t             fifo_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wr_ptr_q;
	logic [OUTQ_AW-1:0]   rd_ptr_q;
	logic [OUTQ_CW-1:0]   count_q;
	logic [OUTQ_CW-1:0]   committed;
	logic                 push;
	logic                 pop;
	out_res_t             entry;

	assign push = res_valid;
	assign pop  = out_valid && !out_stall;

	// Round the finished sum on its way into the queue.
	always_comb begin
		entry.cell_idx = res.cell_idx;
		entry.channel  = res.channel;
		entry.sum      = round_sat(res.acc);
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= entry;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Requests are held off while queued plus in-flight results could fill the queue.
	assign committed = count_q + OUTQ_CW'(pend.s1) + OUTQ_CW'(pend.s2) + OUTQ_CW'(pend.s3);
	assign in_stall  = committed >= OUTQ_CW'(OUTQ_DEPTH);

	assign out_valid   = count_q != '0;
	assign out_cell    = fifo_q[rd_ptr_q].cell_idx;
	assign out_channel = fifo_q[rd_ptr_q].channel;
	assign pooled_sum  = fifo_q[rd_ptr_q].sum;

`ifndef NO_ASSERTIONS
	// The fill count stays within the queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUTQ_CW'(OUTQ_DEPTH))
		else $error("result queue count out of range");

	// A result never arrives at a full queue that is not draining.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && (count_q == OUTQ_CW'(OUTQ_DEPTH))) |-> pop)
		else $error("result queue overflow");

	// A full queue always holds off new requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == OUTQ_CW'(OUTQ_DEPTH)) |-> in_stall)
		else $error("requests not held off at a full queue");
`endif

endmodule

FILE: bench/bev_pillar_pool_forward_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the forward pillar pooling block, with its own pooling predictor.
module bev_pillar_pool_forward_tb;
	import bpp_pkg::*;

	localparam int               CLK_HALF    = 6;
	localparam int               CYCLE_LIMIT = 1000000;
	localparam int               SETTLE_WAIT = 12;
	localparam int               LONG_HOLD   = 300;
	localparam int               PRINT_CAP   = 100;
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);
	localparam logic [CNT_W-1:0] COUNT_NONE  = '0;
	localparam logic [CNT_W-1:0] COUNT_TOP   = '1;
	localparam longint           ACC_HI      = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint           ACC_LO      = -(64'sd1 <<< (ACC_W - 1));
	localparam longint           SUM_HI      = (64'sd1 <<< (SUM_W - 1)) - 1;
	localparam longint           SUM_LO      = -(64'sd1 <<< (SUM_W - 1));

	// One gathered point element, in the order of the block's request fields.
	typedef struct packed {
		logic [W_W-1:0]        weight;
		logic signed [F_W-1:0] feature;
		logic [CH_W-1:0]       ch;
		logic [CELL_W-1:0]     cell_idx;
		logic                  last;
	} point_elem_t;

	logic                    clk            = 1'b0;
	logic                    arst_n         = 1'b0;
	logic                    cfg_write_en   = 1'b0;
	logic [CNT_W-1:0]        cfg_write_data = '0;
	logic                    in_valid       = 1'b0;
	logic                    in_stall;
	logic [W_W-1:0]          depth_weight   = '0;
	logic signed [F_W-1:0]   feature_value  = '0;
	logic [CH_W-1:0]         channel        = '0;
	logic [CELL_W-1:0]       cell_index     = '0;
	logic                    interval_last  = 1'b0;
	logic                    out_valid;
	logic                    out_stall      = 1'b0;
	logic [CELL_W-1:0]       out_cell;
	logic [CH_W-1:0]         out_channel;
	logic signed [SUM_W-1:0] pooled_sum;

	// Pending point elements, expected pooled results and the predictor's copy of the block state.
	point_elem_t      elem_q[$];
	out_res_t         pooled_q[$];
	logic [CNT_W-1:0] count_model;
	longint           chan_acc[MAX_CHANNELS];
	int               errors    = 0;
	int               cycles    = 0;
	bit               fast_feed = 1'b0;
	int               hold_reqs = 0;

	// Sender and receiver pacing state.
	int gap_left   = 0;
	int calm_left  = 0;
	int stall_left = 0;
	int rx_calm    = 0;
	int hold_seen  = 0;

	bev_pillar_pool_forward dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.depth_weight   (depth_weight),
		.feature_value  (feature_value),
		.channel        (channel),
		.cell_index     (cell_index),
		.interval_last  (interval_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_cell       (out_cell),
		.out_channel    (out_channel),
		.pooled_sum     (pooled_sum)
	);

	// Accumulate one element into its channel; on the interval's last point, round and emit.
	function automatic bit pool_element(input point_elem_t e, output out_res_t res);
		int     lim;
		longint acc;
		longint q;
		res = '0;
		lim = (int'(count_model) > MAX_CHANNELS) ? MAX_CHANNELS : int'(count_model);
		if (int'(e.ch) >= lim) return 1'b0;
		acc = chan_acc[e.ch] + longint'(e.weight) * longint'(e.feature);
		if (acc > ACC_HI) acc = ACC_HI;
		else if (acc < ACC_LO) acc = ACC_LO;
		if (!e.last) begin
			chan_acc[e.ch] = acc;
			return 1'b0;
		end
		chan_acc[e.ch] = 0;
		// Round half up from Q.23 to Q.8, then clamp to 32 bits.
		q = (acc + ROUND_BIAS) >>> ROUND_SHIFT;
		if (q > SUM_HI) q = SUM_HI;
		else if (q < SUM_LO) q = SUM_LO;
		res.cell_idx = e.cell_idx;
		res.channel  = e.ch;
		res.sum      = q[SUM_W-1:0];
		return 1'b1;
	endfunction

	// Idle span length: mostly none, sometimes short, rarely long.
	function automatic int idle_span();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [W_W-1:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return W_W'(32768);
			3, 4: return W_W'($urandom);
			default: return W_W'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic signed [F_W-1:0] rand_feature();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return F_W'($urandom);
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		if (errors < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, msg);
		errors = errors + 1;
	endtask

	task automatic push_elem(input logic [W_W-1:0] w, input logic signed [F_W-1:0] f,
			input logic [CH_W-1:0] ch, input logic [CELL_W-1:0] cell_idx, input logic last);
		point_elem_t e;
		e.weight   = w;
		e.feature  = f;
		e.ch       = ch;
		e.cell_idx = cell_idx;
		e.last     = last;
		elem_q.push_back(e);
	endtask

	// Interleaved intervals on up to three neighboring channels, plus some loose elements.
	task automatic push_random_elems(input int n, input int focus);
		int                sent;
		int                k;
		int                j;
		int                base;
		int                live;
		int                left[3];
		logic [CELL_W-1:0] cells[3];
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < 15) begin
				push_elem(rand_weight(), rand_feature(), CH_W'($urandom_range(0, MAX_CHANNELS - 1)),
					CELL_W'($urandom), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				k    = $urandom_range(1, 3);
				base = ($urandom_range(0, 99) < 70) ? $urandom_range(0, focus)
					: $urandom_range(0, MAX_CHANNELS - 1);
				live = 0;
				for (j = 0; j < 3; j++) begin
					if (j >= k) left[j] = 0;
					else if ($urandom_range(0, 9) == 0) left[j] = $urandom_range(6, 14);
					else left[j] = $urandom_range(1, 4);
					cells[j] = CELL_W'($urandom);
					live += left[j];
				end
				while (live > 0) begin
					j = $urandom_range(0, k - 1);
					if (left[j] > 0) begin
						left[j]--;
						live--;
						// Earlier points may carry other cells; the last one decides.
						push_elem(rand_weight(), rand_feature(), CH_W'((base + j) % MAX_CHANNELS),
							(left[j] == 0 || $urandom_range(0, 3) != 0) ? cells[j] : CELL_W'($urandom),
							left[j] == 0);
						sent++;
					end
				end
			end
		end
	endtask

	// Wait until every request is taken and every result is back, then let the pipe drain.
	task automatic settle();
		do @(negedge clk);
		while (elem_q.size() != 0 || in_valid || pooled_q.size() != 0);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] value);
		@(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= value;
		count_model = value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// Request driver: predicts at acceptance, then offers the next pending element.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		point_elem_t nxt;
		point_elem_t taken;
		out_res_t    res;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			gap_left  <= 0;
			calm_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				taken = {depth_weight, feature_value, channel, cell_index, interval_last};
				if (pool_element(taken, res)) pooled_q.push_back(res);
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (elem_q.size() != 0) begin
					nxt = elem_q.pop_front();
					depth_weight  <= nxt.weight;
					feature_value <= nxt.feature;
					channel       <= nxt.ch;
					cell_index    <= nxt.cell_idx;
					interval_last <= nxt.last;
					in_valid      <= 1'b1;
					if (fast_feed) begin
						gap_left <= 0;
					end else if (calm_left > 0) begin
						calm_left <= calm_left - 1;
						gap_left  <= 0;
					end else if ($urandom_range(0, 99) < 4) begin
						calm_left <= $urandom_range(10, 40);
						gap_left  <= 0;
					end else begin
						gap_left <= idle_span();
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each accepted result and paces the output stall.
	always @(posedge clk or negedge arst_n) begin : sink_proc
		out_res_t want;
		int       span;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
			rx_calm    <= 0;
			hold_seen  <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pooled_q.size() == 0) begin
					flag_mismatch($sformatf("result with none pending: cell %0d channel %0d sum %0d",
						out_cell, out_channel, pooled_sum));
				end else begin
					want = pooled_q.pop_front();
					if (out_cell !== want.cell_idx)
						flag_mismatch($sformatf("out_cell got %0d, expected %0d",
							out_cell, want.cell_idx));
					if (out_channel !== want.channel)
						flag_mismatch($sformatf("out_channel got %0d, expected %0d",
							out_channel, want.channel));
					if (pooled_sum !== want.sum)
						flag_mismatch($sformatf("pooled_sum got %0d, expected %0d on channel %0d",
							pooled_sum, want.sum, want.channel));
				end
			end
			if (hold_reqs != hold_seen) begin
				hold_seen  <= hold_reqs;
				stall_left <= LONG_HOLD - 1;
				out_stall  <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= 1'b1;
			end else if (rx_calm > 0) begin
				rx_calm   <= rx_calm - 1;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < 3) begin
				rx_calm   <= $urandom_range(20, 60);
				out_stall <= 1'b0;
			end else begin
				span = idle_span();
				out_stall  <= (span != 0);
				stall_left <= (span > 0) ? span - 1 : 0;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[bev_pillar_pool_forward] ERROR");
			$finish;
		end
	end

	// Stimulus sequence: directed points, then random phases under several channel counts.
	initial begin
		for (int i = 0; i < MAX_CHANNELS; i++) chan_acc[i] = 0;
		count_model = COUNT_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Field extremes, rounding ties and weights above one, under the reset count.
		push_elem(16'h0000, 16'sh7FFF, 6'd0, 20'h00000, 1'b1);
		push_elem(16'hFFFF, 16'sh7FFF, 6'd63, 20'hFFFFF, 1'b1);
		push_elem(16'hFFFF, 16'sh8000, 6'd62, 20'h00001, 1'b1);
		push_elem(16'h8000, 16'sh8000, 6'd1, 20'h55555, 1'b1);
		push_elem(16'h4000, 16'sh0001, 6'd2, 20'hAAAAA, 1'b1);
		push_elem(16'h4000, 16'shFFFF, 6'd3, 20'h00002, 1'b1);
		push_elem(16'h3FFF, 16'sh0001, 6'd4, 20'h00003, 1'b1);
		push_elem(16'h0001, 16'shFFFF, 6'd5, 20'h00004, 1'b1);
		push_elem(16'h8000, 16'sh0100, 6'd6, 20'h00005, 1'b1);

		// Two interleaved intervals back to back; the last point's cell is the one emitted.
		push_elem(16'h1234, 16'sh0200, 6'd10, 20'h00100, 1'b0);
		push_elem(16'h8000, 16'shFF00, 6'd11, 20'h00200, 1'b0);
		push_elem(16'hFFFF, 16'sh7FFF, 6'd10, 20'h00101, 1'b0);
		push_elem(16'h7000, 16'sh8000, 6'd10, 20'h00102, 1'b0);
		push_elem(16'h0800, 16'sh0010, 6'd11, 20'h00200, 1'b1);
		push_elem(16'h0400, 16'sh1234, 6'd10, 20'h00103, 1'b1);
		push_elem(16'h8000, 16'sh0001, 6'd10, 20'h00104, 1'b1);
		push_elem(16'h0000, 16'sh0000, 6'd7, 20'h00000, 1'b0);
		push_elem(16'h0000, 16'sh0000, 6'd7, 20'h00006, 1'b1);
		settle();

		// Random intervals over all channels; the sender then pauses until all results are back.
		push_random_elems(110, MAX_CHANNELS - 1);
		settle();

		// Receiver holds off for a long stretch while single-point intervals keep coming.
		fast_feed = 1'b1;
		hold_reqs = hold_reqs + 1;
		for (int i = 0; i < 40; i++)
			push_elem(rand_weight(), rand_feature(), CH_W'($urandom_range(0, MAX_CHANNELS - 1)),
				CELL_W'($urandom), 1'b1);
		settle();
		fast_feed = 1'b0;

		// One channel in use: everything above channel zero is dropped.
		write_count(CNT_W'(1));
		push_random_elems(30, 0);
		settle();

		// No channels in use: every element is dropped.
		write_count(COUNT_NONE);
		push_random_elems(15, MAX_CHANNELS - 1);
		settle();

		// Count above the store size is limited to all channels.
		write_count(COUNT_TOP);
		push_random_elems(60, MAX_CHANNELS - 1);
		settle();

		// A random partial count.
		write_count(CNT_W'($urandom_range(2, MAX_CHANNELS - 1)));
		push_random_elems(80, int'(count_model) - 1);
		settle();

		// Back to all channels.
		write_count(COUNT_RESET);
		push_random_elems(60, MAX_CHANNELS - 1);
		settle();

		if (errors == 0) begin
			$display("[bev_pillar_pool_forward] OK");
		end else begin
			$display("[bev_pillar_pool_forward] ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/bpp_pkg.sv
sv/bpp_ram.sv
sv/bpp_accum.sv
sv/bpp_outq.sv
sv/bev_pillar_pool_forward.sv
bench/bev_pillar_pool_forward_tb.sv
